>>> rtl/core/assert_macros.svh
// Assertion macros used by the port-level checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property, disabled while reset is asserted.
`define ASSERT_PROP(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);

// Condition that must never hold at a clock edge outside reset.
`define ASSERT_NEVER(lbl, clk, rstn, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) else $error(msg);

`endif

>>> rtl/core/smavg_pkg.sv
// Package: sizes, types and state codes of the moving-average block.
package smavg_pkg;

  localparam int MAX_WINDOW  = 1024;
  localparam int SAMPLE_BITS = 18;
  localparam int IDX_W       = $clog2(MAX_WINDOW);
  localparam int CNT_W       = 11;
  localparam int SUM_W       = SAMPLE_BITS + IDX_W + 1;
  localparam int MAG_W       = SUM_W - 1;
  localparam int FRAC_BITS   = 16;
  localparam int AVG_W       = 34;
  localparam int DIVD_W      = MAG_W + FRAC_BITS;
  localparam int QUO_W       = AVG_W;
  localparam int DHI_W       = DIVD_W - QUO_W;
  localparam int STEP_W      = $clog2(QUO_W + 1);

  typedef enum logic [1:0] {
    S_IDLE,
    S_UPD,
    S_DIV,
    S_DONE
  } smavg_state_e;

  typedef struct packed {
    logic                   rd_en;
    logic [IDX_W-1:0]       rd_addr;
    logic                   we;
    logic [IDX_W-1:0]       wr_addr;
    logic [SAMPLE_BITS-1:0] wr_data;
  } ram_req_t;

  typedef struct packed {
    logic              start;
    logic [DIVD_W-1:0] dividend;
    logic [CNT_W-1:0]  divisor;
  } div_req_t;

endpackage

>>> rtl/core/sliding_window_moving_average.sv
// Moving average over a ring of samples; an input goes through S_UPD, S_DIV, S_DONE.
// One transaction at a time: no input is taken outside S_IDLE; the divider has 34 steps.
// The output register lets the next input enter while a result waits to be taken.
// Reset clears sum, fill count, indices and window (1); store contents stay undefined.
module sliding_window_moving_average import smavg_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   window_size_we_i,
  input  logic [CNT_W-1:0]       window_size_i,
  input  logic                   sample_valid_i,
  output logic                   sample_ready_o,
  input  logic [SAMPLE_BITS-1:0] sample_i,
  output logic                   result_valid_o,
  input  logic                   result_ready_i,
  output logic [AVG_W-1:0]       average_q16_o,
  output logic [CNT_W-1:0]       filled_count_o
);

  smavg_state_e state_q, state_d;

  logic [CNT_W-1:0]       win_q, win_d;
  logic [CNT_W-1:0]       fill_q, fill_d;
  logic [SUM_W-1:0]       sum_q, sum_d;
  logic [IDX_W-1:0]       oldest_q, wr_idx_q;
  logic [SAMPLE_BITS-1:0] sample_q;
  logic                   neg_q;
  logic                   out_valid_q;
  logic [AVG_W-1:0]       avg_q;
  logic [CNT_W-1:0]       cnt_out_q;

  logic                   in_acc;
  logic                   out_load;
  logic                   full;
  logic [SUM_W-1:0]       old_ext, new_ext, sum_abs;
  logic [SAMPLE_BITS-1:0] rd_data;
  logic                   div_done;
  logic [QUO_W-1:0]       quotient;
  ram_req_t               ram_req;
  div_req_t               div_req;

  assign in_acc   = sample_valid_i & sample_ready_o;
  assign out_load = (state_q == S_DONE) && (!out_valid_q || result_ready_i);

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: if (in_acc) state_d = S_UPD;
      S_UPD:  state_d = S_DIV;
      S_DIV:  if (div_done) state_d = S_DONE;
      S_DONE: if (out_load) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    sample_ready_o = (state_q == S_IDLE);
    full    = (fill_q >= win_q);
    old_ext = {{(SUM_W-SAMPLE_BITS){rd_data[SAMPLE_BITS-1]}}, rd_data};
    new_ext = {{(SUM_W-SAMPLE_BITS){sample_q[SAMPLE_BITS-1]}}, sample_q};
    sum_d   = sum_q - (full ? old_ext : '0) + new_ext;
    fill_d  = full ? fill_q : fill_q + 1'b1;
    sum_abs = sum_d[SUM_W-1] ? (~sum_d + 1'b1) : sum_d;

    if (window_size_i == '0) begin
      win_d = CNT_W'(1);
    end else if (window_size_i > CNT_W'(MAX_WINDOW)) begin
      win_d = CNT_W'(MAX_WINDOW);
    end else begin
      win_d = window_size_i;
    end

    ram_req.rd_en   = in_acc;
    ram_req.rd_addr = oldest_q;
    ram_req.we      = (state_q == S_UPD);
    ram_req.wr_addr = wr_idx_q;
    ram_req.wr_data = sample_q;

    div_req.start    = (state_q == S_UPD);
    div_req.dividend = {sum_abs[MAG_W-1:0], {FRAC_BITS{1'b0}}};
    div_req.divisor  = fill_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      win_q       <= CNT_W'(1);
      fill_q      <= '0;
      sum_q       <= '0;
      oldest_q    <= '0;
      wr_idx_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (window_size_we_i) begin
        win_q    <= win_d;
        fill_q   <= '0;
        sum_q    <= '0;
        oldest_q <= wr_idx_q;
      end else if (state_q == S_UPD) begin
        sum_q  <= sum_d;
        fill_q <= fill_d;
        if (full) begin
          oldest_q <= (oldest_q == IDX_W'(MAX_WINDOW - 1)) ? '0 : oldest_q + 1'b1;
        end
        wr_idx_q <= (wr_idx_q == IDX_W'(MAX_WINDOW - 1)) ? '0 : wr_idx_q + 1'b1;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (result_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      sample_q <= sample_i;
    end
    if (state_q == S_UPD) begin
      neg_q <= sum_d[SUM_W-1];
    end
    if (out_load) begin
      avg_q     <= neg_q ? (~quotient + 1'b1) : quotient;
      cnt_out_q <= fill_q;
    end
  end

  smavg_ram u_ram (
    .clk_i     (clk_i),
    .req_i     (ram_req),
    .rd_data_o (rd_data)
  );

  smavg_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .req_i      (div_req),
    .done_o     (div_done),
    .quotient_o (quotient)
  );

  assign result_valid_o = out_valid_q;
  assign average_q16_o  = avg_q;
  assign filled_count_o = cnt_out_q;

endmodule

>>> rtl/core/smavg_ram.sv
// Sample ring store: one write port, one read port, registered read data.
module smavg_ram import smavg_pkg::*; (
  input  logic                   clk_i,
  input  ram_req_t               req_i,
  output logic [SAMPLE_BITS-1:0] rd_data_o
);

  logic [SAMPLE_BITS-1:0] mem [MAX_WINDOW];
  logic [SAMPLE_BITS-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem[req_i.wr_addr] <= req_i.wr_data;
    end
    if (req_i.rd_en) begin
      rd_data_q <= mem[req_i.rd_addr];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

>>> rtl/core/smavg_div.sv
// Restoring divider, one quotient bit per cycle.
module smavg_div import smavg_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  div_req_t         req_i,
  output logic             done_o,
  output logic [QUO_W-1:0] quotient_o
);

  logic [CNT_W-1:0]  rem_q, rem_d;
  logic [QUO_W-1:0]  work_q, work_d;
  logic [CNT_W-1:0]  dvs_q;
  logic [STEP_W-1:0] cnt_q, cnt_d;
  logic              done_q, done_d;
  logic [CNT_W:0]    trial;
  logic [CNT_W:0]    diff;
  logic              ge;

  always_comb begin
    trial = {rem_q, work_q[QUO_W-1]};
    diff  = trial - {1'b0, dvs_q};
    ge    = (trial >= {1'b0, dvs_q});
    rem_d  = rem_q;
    work_d = work_q;
    cnt_d  = cnt_q;
    if (req_i.start) begin
      // top dividend bits are always below the divisor
      rem_d  = CNT_W'(req_i.dividend[DIVD_W-1 -: DHI_W]);
      work_d = req_i.dividend[QUO_W-1:0];
      cnt_d  = STEP_W'(QUO_W);
    end else if (cnt_q != '0) begin
      rem_d  = ge ? diff[CNT_W-1:0] : trial[CNT_W-1:0];
      work_d = {work_q[QUO_W-2:0], ge};
      cnt_d  = cnt_q - 1'b1;
    end
    done_d = (cnt_q == STEP_W'(1)) && !req_i.start;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q  <= rem_d;
    work_q <= work_d;
    if (req_i.start) begin
      dvs_q <= req_i.divisor;
    end
  end

  assign done_o     = done_q;
  assign quotient_o = work_q;

endmodule

>>> rtl/core/smavg_chk.sv
// Port-level checker for the moving-average block, bound to the top level.
`include "assert_macros.svh"

module smavg_chk import smavg_pkg::*; (
  input logic                   clk_i,
  input logic                   rst_ni,
  input logic                   window_size_we_i,
  input logic [CNT_W-1:0]       window_size_i,
  input logic                   sample_valid_i,
  input logic                   sample_ready_o,
  input logic [SAMPLE_BITS-1:0] sample_i,
  input logic                   result_valid_o,
  input logic                   result_ready_i,
  input logic [AVG_W-1:0]       average_q16_o,
  input logic [CNT_W-1:0]       filled_count_o
);

  `ASSERT_PROP(a_out_hold, clk_i, rst_ni, result_valid_o && !result_ready_i |=> result_valid_o, "result dropped before transaction")
  `ASSERT_PROP(a_out_stable, clk_i, rst_ni, result_valid_o && !result_ready_i |=> $stable(average_q16_o) && $stable(filled_count_o), "result changed while stalled")
  `ASSERT_PROP(a_one_at_a_time, clk_i, rst_ni, sample_valid_i && sample_ready_o |=> !sample_ready_o, "input taken while busy")
  `ASSERT_NEVER(a_count_nonzero, clk_i, rst_ni, result_valid_o && (filled_count_o == '0), "result with empty window")

endmodule

bind sliding_window_moving_average smavg_chk u_chk (.*);
